@@ rtl/pnmd_pkg.sv @@
// ----------------------------------------------------------------------------
// pnmd_pkg
// shared types and constants of the pnm pixel stream decoder
// ----------------------------------------------------------------------------
package pnmd_pkg;

  // widths of configuration and raster counters
  localparam int unsigned FMT_W  = 3;
  localparam int unsigned SIZE_W = 13;
  localparam int unsigned GAIN_W = 8;
  localparam int unsigned CFG_W  = 13;
  localparam int unsigned IDX_W  = 2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_FORMAT = 2'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;
  localparam logic [IDX_W-1:0] REG_GAIN   = 2'd3;

  // pnm format numbers
  localparam logic [FMT_W-1:0] FMT_P1 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_P2 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_P3 = 3'd3;
  localparam logic [FMT_W-1:0] FMT_P4 = 3'd4;
  localparam logic [FMT_W-1:0] FMT_P5 = 3'd5;
  localparam logic [FMT_W-1:0] FMT_P6 = 3'd6;

  // ascii codes
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_ONE     = 8'd49;
  localparam logic [7:0] CH_NINE    = 8'd57;
  localparam logic [7:0] CH_HASH    = 8'd35;
  localparam logic [7:0] CH_NEWLINE = 8'd10;

  localparam logic [7:0]  PIX_WHITE = 8'd255;
  localparam logic [7:0]  PIX_BLACK = 8'd0;
  localparam logic [15:0] ACC_MAX   = 16'hFFFF;

  // channel index of the ascii and raw colour modes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // command kinds passed from front to back
  typedef enum logic {
    CMD_PIX  = 1'b0,  // one finished pixel
    CMD_BITS = 1'b1   // packed bitmap byte, up to eight pixels
  } pnmd_kind_t;

  typedef struct packed {
    pnmd_kind_t kind;
    logic [7:0] red;    // packed byte for bitmap commands
    logic [7:0] green;
    logic [7:0] blue;
  } pnmd_cmd_t;

endpackage

@@ rtl/pnmd_front.sv @@
// ----------------------------------------------------------------------------
// pnmd_front
// byte classifier: ascii number parsing, comments and colour assembly
// ----------------------------------------------------------------------------
module pnmd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [7:0]                    data_byte,
  input  logic                          end_of_data,
  input  logic [pnmd_pkg::FMT_W-1:0]    pixel_format,
  input  logic [pnmd_pkg::GAIN_W-1:0]   scale_gain,
  output logic                          push,
  output pnmd_pkg::pnmd_cmd_t           cmd
);
  import pnmd_pkg::*;

  logic        comment_r, comment_nxt;
  logic        digits_r, digits_nxt;
  logic [15:0] accum_r, accum_nxt;
  logic [1:0]  chan_r, chan_nxt;
  logic [7:0]  held_red_r, held_red_nxt;
  logic [7:0]  held_green_r, held_green_nxt;

  logic        is_digit;
  logic [19:0] acc_sum;
  logic [15:0] acc_new;
  logic [15:0] acc_op;
  logic [23:0] prod;
  logic [7:0]  scaled;
  logic        do_finish;
  logic        ascii_mode;

  // digit accumulation, saturating
  assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign acc_sum  = 20'(accum_r) * 20'd10 + 20'(data_byte[3:0]);
  assign acc_new  = (|acc_sum[19:16]) ? ACC_MAX : acc_sum[15:0];

  // number end: a non-digit after digits, or end of data with digits pending
  assign ascii_mode = (pixel_format == FMT_P2) || (pixel_format == FMT_P3);
  always_comb begin
    do_finish = 1'b0;
    acc_op    = accum_r;
    if (ascii_mode) begin
      if (comment_r) begin
        do_finish = end_of_data && digits_r;
      end else if (is_digit) begin
        do_finish = end_of_data;
        acc_op    = acc_new;
      end else begin
        do_finish = digits_r;
      end
    end
  end

  // gain scaling, saturating at full scale
  assign prod   = 24'(acc_op) * 24'(scale_gain);
  assign scaled = (|prod[23:8]) ? PIX_WHITE : prod[7:0];

  // per-byte decode
  always_comb begin
    comment_nxt    = comment_r;
    digits_nxt     = digits_r;
    accum_nxt      = accum_r;
    chan_nxt       = chan_r;
    held_red_nxt   = held_red_r;
    held_green_nxt = held_green_r;
    push           = 1'b0;
    cmd            = '{kind: CMD_PIX, red: data_byte, green: data_byte, blue: data_byte};
    if (accept) begin
      unique case (pixel_format)
        FMT_P1: begin
          if (comment_r) begin
            if (data_byte == CH_NEWLINE) comment_nxt = 1'b0;
          end else if (data_byte == CH_ZERO) begin
            push = 1'b1;
            cmd  = '{kind: CMD_PIX, red: PIX_WHITE, green: PIX_WHITE, blue: PIX_WHITE};
          end else if (data_byte == CH_ONE) begin
            push = 1'b1;
            cmd  = '{kind: CMD_PIX, red: PIX_BLACK, green: PIX_BLACK, blue: PIX_BLACK};
          end else if (data_byte == CH_HASH) begin
            comment_nxt = 1'b1;
          end
        end
        FMT_P2, FMT_P3: begin
          if (comment_r) begin
            if (data_byte == CH_NEWLINE) comment_nxt = 1'b0;
          end else if (is_digit) begin
            accum_nxt  = acc_new;
            digits_nxt = 1'b1;
          end else if (data_byte == CH_HASH) begin
            comment_nxt = 1'b1;
          end
          if (do_finish) begin
            accum_nxt  = '0;
            digits_nxt = 1'b0;
            if (pixel_format == FMT_P2) begin
              push = 1'b1;
              cmd  = '{kind: CMD_PIX, red: scaled, green: scaled, blue: scaled};
            end else if (chan_r == CH_RED) begin
              held_red_nxt = scaled;
              chan_nxt     = CH_GREEN;
            end else if (chan_r == CH_GREEN) begin
              held_green_nxt = scaled;
              chan_nxt       = CH_BLUE;
            end else begin
              chan_nxt = CH_RED;
              push     = 1'b1;
              cmd      = '{kind: CMD_PIX, red: held_red_r, green: held_green_r, blue: scaled};
            end
          end
        end
        FMT_P4: begin
          push     = 1'b1;
          cmd.kind = CMD_BITS;
        end
        FMT_P5: begin
          push = 1'b1;
        end
        FMT_P6: begin
          if (chan_r == CH_RED) begin
            held_red_nxt = data_byte;
            chan_nxt     = CH_GREEN;
          end else if (chan_r == CH_GREEN) begin
            held_green_nxt = data_byte;
            chan_nxt       = CH_BLUE;
          end else begin
            chan_nxt = CH_RED;
            push     = 1'b1;
            cmd      = '{kind: CMD_PIX, red: held_red_r, green: held_green_r, blue: data_byte};
          end
        end
        default: begin
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comment_r    <= 1'b0;
      digits_r     <= 1'b0;
      accum_r      <= '0;
      chan_r       <= CH_RED;
      held_red_r   <= '0;
      held_green_r <= '0;
    end else begin
      comment_r    <= comment_nxt;
      digits_r     <= digits_nxt;
      accum_r      <= accum_nxt;
      chan_r       <= chan_nxt;
      held_red_r   <= held_red_nxt;
      held_green_r <= held_green_nxt;
    end
  end

endmodule

@@ rtl/pnmd_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// pnmd_cmd_fifo
// two-entry command queue between the classifier and the pixel emitter
// ----------------------------------------------------------------------------
module pnmd_cmd_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  pnmd_pkg::pnmd_cmd_t  push_cmd,
  input  logic                 pop,
  output logic                 full,
  output logic                 head_valid,
  output pnmd_pkg::pnmd_cmd_t  head_cmd
);
  import pnmd_pkg::*;

  pnmd_cmd_t  mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_pop;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_cmd   = mem[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/pnmd_back.sv @@
// ----------------------------------------------------------------------------
// pnmd_back
// pixel emitter: raster position, bitmap expansion and output register
// ----------------------------------------------------------------------------
module pnmd_back #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [pnmd_pkg::SIZE_W-1:0]   image_width,
  input  logic [pnmd_pkg::SIZE_W-1:0]   image_height,
  input  logic                          head_valid,
  input  pnmd_pkg::pnmd_cmd_t           head_cmd,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_red,
  output logic [7:0]                    out_green,
  output logic [7:0]                    out_blue,
  output logic                          out_row_end,
  output logic                          out_image_end,
  output logic                          out_run_last
);
  import pnmd_pkg::*;

  localparam logic [16:0] MaxW = 17'(MAX_WIDTH);
  localparam logic [16:0] MaxH = 17'(MAX_HEIGHT);

  logic [SIZE_W-1:0] col_r, col_nxt;
  logic [SIZE_W-1:0] row_r, row_nxt;
  logic              done_r, done_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic              valid_r, valid_nxt;
  logic [7:0]        red_r, green_r, blue_r;
  logic              rend_r, iend_r, last_r;

  logic [SIZE_W-1:0] w_cl, h_cl;
  logic              advance, fire;
  logic              rend, iend, last;
  logic [7:0]        pix_red, pix_green, pix_blue, bit_val;

  // clamp the frame size to 1..max
  always_comb begin
    if (image_width == '0) w_cl = SIZE_W'(1);
    else if ({4'b0, image_width} > MaxW) w_cl = MaxW[SIZE_W-1:0];
    else w_cl = image_width;
    if (image_height == '0) h_cl = SIZE_W'(1);
    else if ({4'b0, image_height} > MaxH) h_cl = MaxH[SIZE_W-1:0];
    else h_cl = image_height;
  end

  // raster end detection for the pixel at the current position
  assign rend = ({1'b0, col_r} + 14'd1) >= {1'b0, w_cl};
  assign iend = rend && (({1'b0, row_r} + 14'd1) >= {1'b0, h_cl});

  // pixel value: finished pixel or one bit of a packed byte, msb first
  assign bit_val = head_cmd.red[3'(3'd7 - bit_r)] ? PIX_BLACK : PIX_WHITE;
  always_comb begin
    if (head_cmd.kind == CMD_BITS) begin
      pix_red   = bit_val;
      pix_green = bit_val;
      pix_blue  = bit_val;
    end else begin
      pix_red   = head_cmd.red;
      pix_green = head_cmd.green;
      pix_blue  = head_cmd.blue;
    end
  end

  // a bitmap byte stops at row end or after its eighth pixel
  assign last    = (head_cmd.kind == CMD_PIX) || rend || (bit_r == 3'd7);
  assign advance = !valid_r || out_ready;
  assign fire    = advance && head_valid && !done_r;
  // after the image, queued commands are dropped
  assign pop     = (fire && last) || (head_valid && done_r);

  // position and sequencing
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    done_nxt  = done_r;
    bit_nxt   = bit_r;
    valid_nxt = valid_r;
    if (advance) valid_nxt = 1'b0;
    if (fire) begin
      valid_nxt = 1'b1;
      bit_nxt   = last ? 3'd0 : bit_r + 3'd1;
      if (rend) begin
        col_nxt = '0;
        if (iend) begin
          row_nxt  = '0;
          done_nxt = 1'b1;
        end else begin
          row_nxt = row_r + SIZE_W'(1);
        end
      end else begin
        col_nxt = col_r + SIZE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      done_r  <= 1'b0;
      bit_r   <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      done_r  <= done_nxt;
      bit_r   <= bit_nxt;
      valid_r <= valid_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (fire) begin
      red_r   <= pix_red;
      green_r <= pix_green;
      blue_r  <= pix_blue;
      rend_r  <= rend;
      iend_r  <= iend;
      last_r  <= last;
    end
  end

  assign out_valid     = valid_r;
  assign out_red       = red_r;
  assign out_green     = green_r;
  assign out_blue      = blue_r;
  assign out_row_end   = rend_r;
  assign out_image_end = iend_r;
  assign out_run_last  = last_r;

`ifndef SYNTH
  // the last pixel of the image closes its row and its run
  a_image_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_end |-> out_row_end && out_run_last)
    else $error("image end without row end or run end");

  // a bitmap expansion in progress always has its byte at the queue head
  a_bits_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r != 3'd0 |-> head_valid && head_cmd.kind == CMD_BITS)
    else $error("bitmap expansion without a bitmap command");

  // the image is only marked done by emitting its last pixel
  a_done_by_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> valid_r && iend_r)
    else $error("image done without last pixel");

  // nothing is loaded into the output once the image is done
  a_quiet_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && $past(done_r) && $past(rst_n) |-> !$rose(valid_r))
    else $error("pixel emitted after image end");
`endif

endmodule

@@ rtl/pnm_pixel_stream_decoder_top.sv @@
// ----------------------------------------------------------------------------
// pnm_pixel_stream_decoder_top
// decodes pnm raster bytes (p1 to p6) into rgb pixels with row and image marks
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  in       input      in_valid/in_ready   in_data_byte, in_end_of_data
//  out      output     out_valid/out_ready out_red/green/blue, out_row_end,
//                                          out_image_end, out_run_last
//  cfg      input      cfg_we              cfg_index, cfg_data
//
//  one byte per cycle is taken while the two-entry command queue has room
//  a p4 byte yields up to eight pixels, one per cycle while out_ready is high
//  a byte's first pixel passes the command queue, then the output register
//  synchronous active-low reset restores defaults; no clearing pass
//  either side may stall on its own; the queue absorbs the difference
// ----------------------------------------------------------------------------
module pnm_pixel_stream_decoder_top #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_data_byte,
  input  logic                         in_end_of_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_red,
  output logic [7:0]                   out_green,
  output logic [7:0]                   out_blue,
  output logic                         out_row_end,
  output logic                         out_image_end,
  output logic                         out_run_last,
  input  logic                         cfg_we,
  input  logic [pnmd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [pnmd_pkg::CFG_W-1:0]   cfg_data
);
  import pnmd_pkg::*;

  logic [FMT_W-1:0]  format_r;
  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;
  logic [GAIN_W-1:0] gain_r;

  logic      accept;
  logic      push, pop, full, head_valid;
  pnmd_cmd_t push_cmd, head_cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_r <= FMT_P6;
      width_r  <= SIZE_W'(1);
      height_r <= SIZE_W'(1);
      gain_r   <= GAIN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FORMAT: format_r <= cfg_data[FMT_W-1:0];
        REG_WIDTH:  width_r  <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[SIZE_W-1:0];
        REG_GAIN:   gain_r   <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  pnmd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .data_byte    (in_data_byte),
    .end_of_data  (in_end_of_data),
    .pixel_format (format_r),
    .scale_gain   (gain_r),
    .push         (push),
    .cmd          (push_cmd)
  );

  pnmd_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  pnmd_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .image_width   (width_r),
    .image_height  (height_r),
    .head_valid    (head_valid),
    .head_cmd      (head_cmd),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_row_end   (out_row_end),
    .out_image_end (out_image_end),
    .out_run_last  (out_run_last)
  );

endmodule
